@@ rtl/ctsdh_pkg.sv @@
// Shared types and constants for the clock-to-select delay histogram.
// Used by the top level and by the port checker; depends on nothing else.
package ctsdh_pkg;

    // configuration register indexes
    localparam logic REG_SELECT_BIT = 1'b0;
    localparam logic REG_CLOCK_BIT  = 1'b1;

    // action codes carried on s_tuser
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // result kinds carried on m_tuser
    localparam logic RES_REPORT = 1'b0;
    localparam logic RES_READ   = 1'b1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;
    localparam int IDX_W     = 16;
    localparam int COUNT_W   = 32;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   delay;
        logic               fast;
        logic               counted;
        logic               bad;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

@@ rtl/clock_to_select_delay_histogram.sv @@
// Top level of the clock-to-select delay histogram: capture edge tracking,
// the fast and slow histogram memories and the two-entry result queue.
// Depends on ctsdh_pkg.
//
// Usage:
//   s_ channel: one item per handshake. s_tuser = 0 takes one sample byte
//   (s_tlast marks the last sample of a capture); s_tuser = 1 reads one
//   histogram bin (s_tdata table_select and bin_index).
//   m_ channel: one result per capture end (m_tuser = 0, report) and one per
//   bin read (m_tuser = 1). Samples without s_tlast give no result.
//   cfg_ port: cfg_wr_index 0 sets the select bit, 1 sets the clock bit.
// Throughput: one item per cycle while s_tready is high. The histograms
//   are single-port-write memories; each counted capture does one
//   read-modify-write on its bin, with the running totals held in
//   registers. A read that follows an increment of the same bin gets the
//   new value by forwarding. An accepted item is registered in stage 1,
//   then written into the result queue, which drives m_tvalid.
// Reset: aresetn clears the capture state and totals, then a clearing pass
//   zeroes the bins of both histograms; s_tready stays low during the pass.
// Stall: results wait in a two-entry queue; after the clearing pass, s_tready
//   drops only when the queue and the item in flight would fill it.
module clock_to_select_delay_histogram #(
    parameter int FAST_PERIOD = 32,
    parameter int SLOW_PERIOD = 250,
    parameter int MAX_CAPTURE = 32768,
    parameter int MIN_CAPTURE = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] sample_byte, [8] table_select, [16:9] bin_index
    input  logic [ctsdh_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] measured_delay, [16] is_fast, [17] counted, [18] bad_capture,
    // [50:19] bin_count
    output logic [ctsdh_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] result_kind
    output logic                           m_tuser,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_index,
    input  logic [2:0]                     cfg_wr_data
);

    localparam int FA_W      = $clog2(FAST_PERIOD);
    localparam int SA_W      = $clog2(SLOW_PERIOD);
    localparam int CLR_DEPTH = (FAST_PERIOD > SLOW_PERIOD) ? FAST_PERIOD : SLOW_PERIOD;
    localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
    localparam int IW        = ctsdh_pkg::IDX_W;
    localparam int CW        = ctsdh_pkg::COUNT_W;

    // configuration
    logic [2:0] select_bit_reg;
    logic [2:0] clock_bit_reg;

    // capture state
    logic [7:0]    prev_reg,       prev_next;
    logic [IW-1:0] idx_reg,        idx_next;
    logic [IW-1:0] fall_idx_reg,   fall_idx_next;
    logic          fall_seen_reg,  fall_seen_next;
    logic          sel_found_reg,  sel_found_next;
    logic [IW-1:0] held_reg,       held_next;
    logic [IW-1:0] first_rise_reg, first_rise_next;
    logic [1:0]    rise_cnt_reg,   rise_cnt_next;
    logic [IW-1:0] period_reg,     period_next;

    logic [7:0]    prev_upd;
    logic [IW-1:0] idx_upd, fall_idx_upd, held_upd, first_rise_upd, period_upd;
    logic          fall_seen_upd, sel_found_upd;
    logic [1:0]    rise_cnt_upd;

    logic [CW-1:0] fast_total_reg, slow_total_reg;

    // clearing pass
    logic             clr_active_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    // input decode
    logic          in_acc, is_sample, is_read, is_report;
    logic [7:0]    sample;
    logic          tsel;
    logic [IW-1:0] bin16;
    logic          active, has_prev, cp, cn, sp, sn, c_fall, c_rise, s_rise;

    // report fields
    logic          rpt_bad, rpt_fast, rpt_counted, clk_bad;
    logic [IW-1:0] rpt_delay;
    logic          inc_fast, inc_slow;
    logic          rd_hit, rd_total;
    logic [CW-1:0] rd_const;

    // memories
    logic [CW-1:0]   fast_mem [FAST_PERIOD];
    logic [CW-1:0]   slow_mem [SLOW_PERIOD];
    logic [FA_W-1:0] f_raddr, f_waddr;
    logic [SA_W-1:0] s_raddr, s_waddr;
    logic [CW-1:0]   f_rdata_reg, s_rdata_reg, f_data, s_data, f_wdata, s_wdata;
    logic            f_we, s_we;

    // forwarding of the last write into each memory
    logic            fwd_f_valid_reg, fwd_s_valid_reg;
    logic [FA_W-1:0] fwd_f_addr_reg;
    logic [SA_W-1:0] fwd_s_addr_reg;
    logic [CW-1:0]   fwd_f_data_reg, fwd_s_data_reg;

    // stage 1
    logic                s1_valid_reg;
    logic                s1_use_mem_reg;
    logic                s1_inc_f_reg, s1_inc_s_reg;
    logic                s1_tsel_reg;
    logic [FA_W-1:0]     s1_faddr_reg;
    logic [SA_W-1:0]     s1_saddr_reg;
    ctsdh_pkg::result_t  s1_res_reg, s1_res, in_res;

    // result queue
    ctsdh_pkg::result_t q_mem_reg [2];
    logic               q_wr_ptr_reg, q_rd_ptr_reg;
    logic [1:0]         q_cnt_reg;
    logic               push, pop;
    ctsdh_pkg::result_t q_head;

    assign in_acc    = s_tvalid && s_tready;
    assign sample    = s_tdata[7:0];
    assign tsel      = s_tdata[8];
    assign bin16     = {8'd0, s_tdata[16:9]};
    assign is_sample = in_acc && (s_tuser == ctsdh_pkg::ACT_SAMPLE);
    assign is_read   = in_acc && (s_tuser == ctsdh_pkg::ACT_READ);
    assign is_report = is_sample && s_tlast;

    assign active   = idx_reg < IW'(MAX_CAPTURE);
    assign has_prev = idx_reg != '0;
    assign cp = prev_reg[clock_bit_reg];
    assign cn = sample[clock_bit_reg];
    assign sp = prev_reg[select_bit_reg];
    assign sn = sample[select_bit_reg];
    assign c_fall = active && has_prev && cp && !cn;
    assign c_rise = active && has_prev && !cp && cn;
    assign s_rise = active && has_prev && !sp && sn && !sel_found_reg;

    // edge tracking for the current sample
    always_comb begin
        prev_upd       = prev_reg;
        idx_upd        = idx_reg;
        fall_idx_upd   = fall_idx_reg;
        fall_seen_upd  = fall_seen_reg;
        sel_found_upd  = sel_found_reg;
        held_upd       = held_reg;
        first_rise_upd = first_rise_reg;
        rise_cnt_upd   = rise_cnt_reg;
        period_upd     = period_reg;
        if (c_fall) begin
            fall_idx_upd  = idx_reg;
            fall_seen_upd = 1'b1;
        end
        if (c_rise) begin
            if (rise_cnt_reg == 2'd0) begin
                first_rise_upd = idx_reg;
                rise_cnt_upd   = 2'd1;
            end else if (rise_cnt_reg == 2'd1) begin
                period_upd   = idx_reg - first_rise_reg;
                rise_cnt_upd = 2'd2;
            end
        end
        if (s_rise) begin
            sel_found_upd = 1'b1;
            held_upd      = fall_seen_upd ? (idx_reg - fall_idx_upd) : '0;
        end
        if (active) begin
            prev_upd = sample;
            idx_upd  = idx_reg + 1'b1;
        end
    end

    // capture report from the updated state
    always_comb begin
        rpt_bad     = 1'b0;
        rpt_fast    = 1'b0;
        rpt_counted = 1'b0;
        rpt_delay   = '0;
        clk_bad     = 1'b0;
        if (idx_upd < IW'(MIN_CAPTURE)) begin
            rpt_bad = 1'b1;
        end else begin
            if (sel_found_upd) begin
                if (fall_seen_upd) begin
                    rpt_delay = held_upd;
                end else begin
                    clk_bad = 1'b1;
                end
            end else begin
                rpt_delay = idx_upd;
            end
            if (rise_cnt_upd != 2'd2) begin
                clk_bad = 1'b1;
            end else begin
                rpt_fast = period_upd <= IW'(FAST_PERIOD);
            end
            rpt_bad = clk_bad;
            if (!clk_bad) begin
                rpt_counted = rpt_fast ? (rpt_delay < IW'(FAST_PERIOD))
                                       : (rpt_delay < IW'(SLOW_PERIOD));
            end
        end
    end

    assign inc_fast = is_report && rpt_counted && rpt_fast;
    assign inc_slow = is_report && rpt_counted && !rpt_fast;

    assign rd_hit   = tsel ? (bin16 < IW'(SLOW_PERIOD)) : (bin16 < IW'(FAST_PERIOD));
    assign rd_total = tsel ? (bin16 == IW'(SLOW_PERIOD)) : (bin16 == IW'(FAST_PERIOD));
    assign rd_const = rd_total ? (tsel ? slow_total_reg : fast_total_reg) : '0;

    always_comb begin
        in_res = '0;
        if (s_tuser == ctsdh_pkg::ACT_READ) begin
            in_res.kind  = ctsdh_pkg::RES_READ;
            in_res.count = rd_const;
        end else begin
            in_res.kind    = ctsdh_pkg::RES_REPORT;
            in_res.delay   = rpt_delay;
            in_res.fast    = rpt_fast;
            in_res.counted = rpt_counted;
            in_res.bad     = rpt_bad;
        end
    end

    assign f_raddr = (s_tuser == ctsdh_pkg::ACT_READ) ? bin16[FA_W-1:0] : rpt_delay[FA_W-1:0];
    assign s_raddr = (s_tuser == ctsdh_pkg::ACT_READ) ? bin16[SA_W-1:0] : rpt_delay[SA_W-1:0];

    // capture state next values: clear after each report
    always_comb begin
        prev_next       = prev_reg;
        idx_next        = idx_reg;
        fall_idx_next   = fall_idx_reg;
        fall_seen_next  = fall_seen_reg;
        sel_found_next  = sel_found_reg;
        held_next       = held_reg;
        first_rise_next = first_rise_reg;
        rise_cnt_next   = rise_cnt_reg;
        period_next     = period_reg;
        if (is_report) begin
            prev_next       = '0;
            idx_next        = '0;
            fall_idx_next   = '0;
            fall_seen_next  = 1'b0;
            sel_found_next  = 1'b0;
            held_next       = '0;
            first_rise_next = '0;
            rise_cnt_next   = '0;
            period_next     = '0;
        end else if (is_sample) begin
            prev_next       = prev_upd;
            idx_next        = idx_upd;
            fall_idx_next   = fall_idx_upd;
            fall_seen_next  = fall_seen_upd;
            sel_found_next  = sel_found_upd;
            held_next       = held_upd;
            first_rise_next = first_rise_upd;
            rise_cnt_next   = rise_cnt_upd;
            period_next     = period_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_bit_reg <= 3'd0;
            clock_bit_reg  <= 3'd1;
            prev_reg       <= '0;
            idx_reg        <= '0;
            fall_idx_reg   <= '0;
            fall_seen_reg  <= 1'b0;
            sel_found_reg  <= 1'b0;
            held_reg       <= '0;
            first_rise_reg <= '0;
            rise_cnt_reg   <= '0;
            period_reg     <= '0;
            fast_total_reg <= '0;
            slow_total_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    ctsdh_pkg::REG_SELECT_BIT: select_bit_reg <= cfg_wr_data;
                    ctsdh_pkg::REG_CLOCK_BIT:  clock_bit_reg  <= cfg_wr_data;
                endcase
            end
            prev_reg       <= prev_next;
            idx_reg        <= idx_next;
            fall_idx_reg   <= fall_idx_next;
            fall_seen_reg  <= fall_seen_next;
            sel_found_reg  <= sel_found_next;
            held_reg       <= held_next;
            first_rise_reg <= first_rise_next;
            rise_cnt_reg   <= rise_cnt_next;
            period_reg     <= period_next;
            if (inc_fast) begin
                fast_total_reg <= fast_total_reg + 1'b1;
            end
            if (inc_slow) begin
                slow_total_reg <= slow_total_reg + 1'b1;
            end
        end
    end

    // clearing pass over both histograms
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (clr_active_reg) begin
            if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // stage 1: memory data is back, take the last write if it hit this bin
    assign f_data = (fwd_f_valid_reg && fwd_f_addr_reg == s1_faddr_reg) ? fwd_f_data_reg
                                                                        : f_rdata_reg;
    assign s_data = (fwd_s_valid_reg && fwd_s_addr_reg == s1_saddr_reg) ? fwd_s_data_reg
                                                                        : s_rdata_reg;

    always_comb begin
        f_we    = s1_valid_reg && s1_inc_f_reg;
        f_waddr = s1_faddr_reg;
        f_wdata = f_data + 1'b1;
        s_we    = s1_valid_reg && s1_inc_s_reg;
        s_waddr = s1_saddr_reg;
        s_wdata = s_data + 1'b1;
        if (clr_active_reg) begin
            f_we    = clr_cnt_reg < CLR_W'(FAST_PERIOD);
            f_waddr = clr_cnt_reg[FA_W-1:0];
            f_wdata = '0;
            s_we    = clr_cnt_reg < CLR_W'(SLOW_PERIOD);
            s_waddr = clr_cnt_reg[SA_W-1:0];
            s_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_we) begin
            fast_mem[f_waddr] <= f_wdata;
        end
        f_rdata_reg <= fast_mem[f_raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_we) begin
            slow_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= slow_mem[s_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_f_valid_reg <= 1'b0;
            fwd_s_valid_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end else begin
            fwd_f_valid_reg <= s1_valid_reg && s1_inc_f_reg;
            fwd_s_valid_reg <= s1_valid_reg && s1_inc_s_reg;
            s1_valid_reg    <= is_read || is_report;
        end
        fwd_f_addr_reg <= s1_faddr_reg;
        fwd_f_data_reg <= f_wdata;
        fwd_s_addr_reg <= s1_saddr_reg;
        fwd_s_data_reg <= s_wdata;
        s1_use_mem_reg <= (s_tuser == ctsdh_pkg::ACT_READ) && rd_hit;
        s1_inc_f_reg   <= inc_fast;
        s1_inc_s_reg   <= inc_slow;
        s1_faddr_reg   <= f_raddr;
        s1_saddr_reg   <= s_raddr;
        s1_res_reg     <= in_res;
        s1_tsel_reg    <= tsel;
    end

    always_comb begin
        s1_res = s1_res_reg;
        if (s1_res_reg.kind == ctsdh_pkg::RES_READ && s1_use_mem_reg) begin
            s1_res.count = s1_tsel_reg ? s_data : f_data;
        end
    end

    // result queue
    assign push   = s1_valid_reg;
    assign pop    = m_tvalid && m_tready;
    assign q_head = q_mem_reg[q_rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_cnt_reg    <= '0;
        end else begin
            if (push) begin
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            end
            if (pop) begin
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            end
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) begin
            q_mem_reg[q_wr_ptr_reg] <= s1_res;
        end
    end

    // hold off input when the queue could not take the item in flight
    assign s_tready = !clr_active_reg &&
                      ((3'(q_cnt_reg) + 3'(s1_valid_reg)) < (3'd2 + 3'(pop)));
    assign m_tvalid = q_cnt_reg != 2'd0;
    assign m_tuser  = q_head.kind;
    assign m_tdata  = {5'd0, q_head.count, q_head.bad, q_head.counted,
                       q_head.fast, q_head.delay};

endmodule

@@ rtl/ctsdh_checker.sv @@
// Port-level checks for the clock-to-select delay histogram, bound to the
// top level. Depends on ctsdh_pkg.
module ctsdh_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ctsdh_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    // no item is taken right after reset, when the clearing of the bins begins
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken right after reset");

    a_read_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ctsdh_pkg::RES_READ |-> m_tdata[18:0] == 19'd0)
        else $error("bin read carries report fields");

    a_report_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ctsdh_pkg::RES_REPORT |->
            m_tdata[50:19] == 32'd0 && !(m_tdata[17] && m_tdata[18]))
        else $error("report has a bin count or counts a bad capture");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind clock_to_select_delay_histogram ctsdh_checker u_ctsdh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
